FILE: rtl/weighted_mean_3x3_smoother_defines.svh
// Assertion macros for the weighted 3x3 mean smoother.
// Used by the port checker; expects aclk and aresetn in the calling scope.
`ifndef WEIGHTED_MEAN_3X3_SMOOTHER_DEFINES_SVH
`define WEIGHTED_MEAN_3X3_SMOOTHER_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define WM3S_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wm3s: same-cycle check failed");

// Next-cycle implication, off while reset is asserted
`define WM3S_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wm3s: next-cycle check failed");

// Condition that must hold in the cycle after a reset edge
`define WM3S_ASSERT_RST(lbl, cons) \
    lbl: assert property (@(posedge aclk) (!aresetn) |=> (cons)) \
        else $error("wm3s: post-reset check failed");

`endif

FILE: rtl/wm3s_pkg.sv
// Shared types, constants and helper functions of the weighted 3x3 mean smoother.
// No dependencies; imported by every module of the block.
package wm3s_pkg;

    // Default frame limits
    localparam int DEF_MAX_WIDTH  = 512;
    localparam int DEF_MAX_HEIGHT = 512;

    // Field and register widths
    localparam int PIXEL_W   = 8;
    localparam int CFG_W     = 10;
    localparam int CFG_IDX_W = 2;
    localparam int SUM_W     = 12;   // 10 * 255 fits in 12 bits
    localparam int BANKS     = 3;

    // Register map
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

    localparam int IMAGE_WIDTH_RESET  = 512;
    localparam int IMAGE_HEIGHT_RESET = 512;
    localparam int MIN_DIM            = 2;

    // Item kinds
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    // s / 10 == (s * 6554) >> 16 for every s up to 2550
    localparam int DIV10_MUL   = 6554;
    localparam int DIV10_SHIFT = 16;

    // Result stage occupancy
    localparam logic [1:0] OUT_EMPTY = 2'd0;
    localparam logic [1:0] OUT_ONE   = 2'd1;
    localparam logic [1:0] OUT_TWO   = 2'd2;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // One window column: top = two rows up, mid = center row, bot = newest row
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    // Line store control from the top level
    typedef struct packed {
        logic             wr_en;
        logic [BANKS-1:0] wr_sel;
        logic             rd_en;
    } ls_ctrl_t;

    // What travels with an item from the fetch stage to the window stage
    typedef struct packed {
        logic             drain;
        logic             col_first;
        logic             zero_top;
        logic             zero_mid;
        pixel_t           bot;
        logic [BANKS-1:0] sel_top;
        logic [BANKS-1:0] sel_mid;
        logic             emit0;
        logic             emit1;
        logic             last;
    } fetch_t;

    // Result bookkeeping for the later stages
    typedef struct packed {
        logic emit0;
        logic emit1;
        logic last;
    } emit_t;

    function automatic logic [SUM_W-1:0] column_sum(column_t c);
        return SUM_W'(c.top) + SUM_W'(c.mid) + SUM_W'(c.bot);
    endfunction

    function automatic pixel_t div10(logic [SUM_W-1:0] s);
        logic [31:0] prod;
        prod = 32'(s) * 32'(DIV10_MUL);
        return prod[DIV10_SHIFT +: PIXEL_W];
    endfunction

    // One-hot bank select over the three line store read ports
    function automatic pixel_t pick_bank(logic [BANKS-1:0] sel,
                                         logic [BANKS-1:0][PIXEL_W-1:0] d);
        pixel_t r;
        r = '0;
        for (int b = 0; b < BANKS; b++) begin
            r = r | (d[b] & {PIXEL_W{sel[b]}});
        end
        return r;
    endfunction

endpackage

FILE: rtl/wm3s_line_store.sv
// Three-bank line store of the weighted 3x3 mean smoother, one row per bank.
// Depends on wm3s_pkg. Contents are not cleared by reset.
module wm3s_line_store import wm3s_pkg::*; #(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic                            aclk,
    input  ls_ctrl_t                        ctrl,
    input  logic [$clog2(MAX_WIDTH)-1:0]    wr_addr,
    input  pixel_t                          wr_data,
    input  logic [$clog2(MAX_WIDTH)-1:0]    rd_addr,
    output logic [BANKS-1:0][PIXEL_W-1:0]   rd_data
);

    // Each bank: one write port, one registered read port at the shared address
    for (genvar b = 0; b < BANKS; b++) begin : g_bank
        pixel_t mem [MAX_WIDTH];
        pixel_t rd_q_reg;

        always_ff @(posedge aclk) begin
            if (ctrl.wr_en && ctrl.wr_sel[b]) begin
                mem[wr_addr] <= wr_data;
            end
            if (ctrl.rd_en) begin
                rd_q_reg <= mem[rd_addr];
            end
        end

        assign rd_data[b] = rd_q_reg;
    end

endmodule

FILE: rtl/weighted_mean_3x3_smoother.sv
// Top level of the weighted 3x3 mean smoother: counters, window pipeline, result stage.
// Depends on wm3s_pkg and wm3s_line_store.
//
//  channel  | dir | data                  | tlast   | tuser
//  ---------+-----+-----------------------+---------+-----------
//  s_       | in  | pixel_value [7:0]     | -       | operation
//  m_       | out | smoothed_value [7:0]  | row_end | frame_end
//  cfg_wr_  | in  | index 0 width, 1 height, data [9:0], no read-back
//
// One input item per cycle unless m_ stalls or a row end's second result is held.
// Stages: fetch (line store read), window shift, weighted sum, divide into result.
// A row's last pixel gives two results; the result stage takes no new sum while the second waits.
// aresetn (sync, active low) clears counters and valid bits, presets width and height;
// the line store is not cleared. Backpressure on m_ stalls only the stages behind it.
module weighted_mean_3x3_smoother import wm3s_pkg::*; #(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input items
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [PIXEL_W-1:0]   s_tdata,    // [7:0] pixel_value
    input  logic                 s_tuser,    // [0] operation
    // Result items
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [PIXEL_W-1:0]   m_tdata,    // [7:0] smoothed_value
    output logic                 m_tlast,    // row_end
    output logic                 m_tuser,    // [0] frame_end
    // Configuration
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [CFG_W-1:0]     cfg_wr_data
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int WIDTH_RST  = (IMAGE_WIDTH_RESET  > MAX_WIDTH)  ? MAX_WIDTH  : IMAGE_WIDTH_RESET;
    localparam int HEIGHT_RST = (IMAGE_HEIGHT_RESET > MAX_HEIGHT) ? MAX_HEIGHT : IMAGE_HEIGHT_RESET;
    localparam logic [BANKS-1:0] BANK_FIRST = BANKS'(1);

    // ---------------- frame state ----------------
    logic [WW-1:0]    width_reg,  width_next;
    logic [RW-1:0]    height_reg, height_next;
    logic [AW-1:0]    col_reg,    col_next;
    logic [RW-1:0]    row_reg,    row_next;
    logic [AW-1:0]    drain_reg,  drain_next;
    logic [BANKS-1:0] bank_reg,   bank_next;

    logic [31:0]      cfg_val;
    logic [WW-1:0]    width_sat;
    logic [RW-1:0]    height_sat;
    logic             cfg_hit;

    logic             draining;
    logic [WW-1:0]    col_plus1;
    logic [WW-1:0]    drain_plus1;
    logic             row_last_col;
    logic             drain_last;
    logic             accept;
    logic             take_pixel;
    logic             take_flush;
    logic [BANKS-1:0] bank_prev;
    logic [BANKS-1:0] bank_prev2;
    logic [AW-1:0]    rd_addr;

    // ---------------- pipeline ----------------
    logic     a_valid_reg, a_valid_next;
    fetch_t   fetch_reg, fetch_next;
    logic [BANKS-1:0][PIXEL_W-1:0] rd_data;
    ls_ctrl_t ls_ctrl;

    logic     b_valid_reg;
    emit_t    b_emit_reg;
    column_t  left_reg, center_reg, right_reg, col0_reg;
    column_t  col_new;

    logic     c_valid_reg;
    emit_t    c_emit_reg;
    logic [SUM_W-1:0] sum0_reg, sum0_next, sum1_reg, sum1_next;

    logic [1:0] out_cnt_reg, out_cnt_next;
    pixel_t     slot0_value_reg, slot0_value_next;
    logic       slot0_row_end_reg, slot0_row_end_next;
    logic       slot0_frame_end_reg, slot0_frame_end_next;
    pixel_t     slot1_value_reg, slot1_value_next;

    logic out_free, out_load, en_c, en_b;

    // Saturate configuration writes into the supported range
    always_comb begin
        cfg_val    = 32'(cfg_wr_data);
        width_sat  = (cfg_val < 32'(MIN_DIM))   ? WW'(MIN_DIM) :
                     (cfg_val > 32'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_val);
        height_sat = (cfg_val < 32'(MIN_DIM))    ? RW'(MIN_DIM) :
                     (cfg_val > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT) : RW'(cfg_val);
        cfg_hit    = cfg_wr_en && ((cfg_wr_index == REG_IMAGE_WIDTH) ||
                                   (cfg_wr_index == REG_IMAGE_HEIGHT));
    end

    // Frame position decode
    assign draining     = (row_reg >= height_reg);
    assign col_plus1    = WW'(col_reg) + WW'(1);
    assign drain_plus1  = WW'(drain_reg) + WW'(1);
    assign row_last_col = (col_plus1 == width_reg);
    assign drain_last   = (drain_plus1 >= width_reg);
    assign accept       = s_tvalid && s_tready;
    assign take_pixel   = accept && !draining && (s_tuser == OP_PIXEL);
    assign take_flush   = accept && draining && (s_tuser == OP_FLUSH);
    // Rows rotate through the banks: bank_reg holds row r, these hold r-1 and r-2
    assign bank_prev    = {bank_reg[0], bank_reg[BANKS-1:1]};
    assign bank_prev2   = {bank_reg[BANKS-2:0], bank_reg[BANKS-1]};
    assign rd_addr      = draining ? drain_plus1[AW-1:0] : col_reg;

    // Counter and register updates
    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        col_next    = col_reg;
        row_next    = row_reg;
        drain_next  = drain_reg;
        bank_next   = bank_reg;
        if (cfg_hit) begin
            if (cfg_wr_index == REG_IMAGE_WIDTH) begin
                width_next = width_sat;
            end else begin
                height_next = height_sat;
            end
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
            bank_next  = BANK_FIRST;
        end else if (take_pixel) begin
            if (row_last_col) begin
                col_next  = '0;
                row_next  = RW'(row_reg + RW'(1));
                bank_next = {bank_reg[BANKS-2:0], bank_reg[BANKS-1]};
            end else begin
                col_next = AW'(col_reg + AW'(1));
            end
        end else if (take_flush) begin
            if (drain_last) begin
                col_next   = '0;
                row_next   = '0;
                drain_next = '0;
                bank_next  = BANK_FIRST;
            end else begin
                drain_next = AW'(drain_reg + AW'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(WIDTH_RST);
            height_reg <= RW'(HEIGHT_RST);
            col_reg    <= '0;
            row_reg    <= '0;
            drain_reg  <= '0;
            bank_reg   <= BANK_FIRST;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            drain_reg  <= drain_next;
            bank_reg   <= bank_next;
        end
    end

    // ---------------- stage handshakes ----------------
    assign out_free = (out_cnt_reg == OUT_EMPTY) || ((out_cnt_reg == OUT_ONE) && m_tready);
    assign out_load = c_valid_reg && c_emit_reg.emit0 && out_free;
    assign en_c     = !c_valid_reg || !c_emit_reg.emit0 || out_free;
    assign en_b     = !b_valid_reg || en_c;
    assign s_tready = !a_valid_reg || en_b;

    // ---------------- fetch stage ----------------
    always_comb begin
        fetch_next.drain     = draining;
        fetch_next.col_first = draining ? (drain_reg == '0) : (col_reg == '0);
        fetch_next.zero_top  = draining ? drain_last : (row_reg < RW'(2));
        fetch_next.zero_mid  = draining ? drain_last : (row_reg == '0);
        fetch_next.bot       = draining ? '0 : s_tdata;
        fetch_next.sel_top   = bank_prev2;
        fetch_next.sel_mid   = bank_prev;
        fetch_next.emit0     = draining || ((row_reg != '0) && (col_reg != '0));
        fetch_next.emit1     = !draining && (row_reg != '0) && (col_reg != '0) && row_last_col;
        fetch_next.last      = draining && drain_last;
        a_valid_next         = s_tready ? (take_pixel || take_flush) : a_valid_reg;
    end

    assign ls_ctrl.wr_en  = take_pixel;
    assign ls_ctrl.wr_sel = bank_reg;
    assign ls_ctrl.rd_en  = s_tready;

    wm3s_line_store #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_line_store (
        .aclk    (aclk),
        .ctrl    (ls_ctrl),
        .wr_addr (col_reg),
        .wr_data (s_tdata),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
        if (s_tready) begin
            fetch_reg <= fetch_next;
        end
    end

    // ---------------- window stage ----------------
    always_comb begin
        col_new.top = fetch_reg.zero_top ? '0 : pick_bank(fetch_reg.sel_top, rd_data);
        col_new.mid = fetch_reg.zero_mid ? '0 : pick_bank(fetch_reg.sel_mid, rd_data);
        col_new.bot = fetch_reg.bot;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (en_b) begin
            b_valid_reg <= a_valid_reg;
        end
        if (en_b && a_valid_reg) begin
            b_emit_reg <= '{emit0: fetch_reg.emit0, emit1: fetch_reg.emit1,
                            last: fetch_reg.last};
            if (fetch_reg.col_first && !fetch_reg.drain) begin
                // Row start: nothing to the left of column zero
                left_reg   <= '0;
                center_reg <= '0;
                right_reg  <= col_new;
                // Keep column zero of the two newest rows for the drain start
                col0_reg   <= '{top: col_new.mid, mid: col_new.bot, bot: '0};
            end else if (fetch_reg.col_first) begin
                left_reg   <= '0;
                center_reg <= col0_reg;
                right_reg  <= col_new;
            end else begin
                left_reg   <= center_reg;
                center_reg <= right_reg;
                right_reg  <= col_new;
            end
        end
    end

    // ---------------- weighted sum stage ----------------
    // Centered on the middle column, and for a row's last position on the right column
    always_comb begin
        sum0_next = column_sum(left_reg) + column_sum(center_reg) + column_sum(right_reg)
                  + SUM_W'(center_reg.mid);
        sum1_next = column_sum(center_reg) + column_sum(right_reg) + SUM_W'(right_reg.mid);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (en_c) begin
            c_valid_reg <= b_valid_reg;
        end
        if (en_c && b_valid_reg) begin
            c_emit_reg <= b_emit_reg;
            sum0_reg   <= sum0_next;
            sum1_reg   <= sum1_next;
        end
    end

    // ---------------- result stage ----------------
    always_comb begin
        out_cnt_next         = out_cnt_reg;
        slot0_value_next     = slot0_value_reg;
        slot0_row_end_next   = slot0_row_end_reg;
        slot0_frame_end_next = slot0_frame_end_reg;
        slot1_value_next     = slot1_value_reg;
        if (out_load) begin
            slot0_value_next     = div10(sum0_reg);
            slot0_row_end_next   = c_emit_reg.last;
            slot0_frame_end_next = c_emit_reg.last;
            slot1_value_next     = div10(sum1_reg);
            out_cnt_next         = c_emit_reg.emit1 ? OUT_TWO : OUT_ONE;
        end else if (m_tready) begin
            case (out_cnt_reg)
                OUT_TWO: begin
                    // Second result of a row end moves up
                    slot0_value_next     = slot1_value_reg;
                    slot0_row_end_next   = 1'b1;
                    slot0_frame_end_next = 1'b0;
                    out_cnt_next         = OUT_ONE;
                end
                OUT_ONE: begin
                    out_cnt_next = OUT_EMPTY;
                end
                default: begin
                    out_cnt_next = out_cnt_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_cnt_reg <= OUT_EMPTY;
        end else begin
            out_cnt_reg <= out_cnt_next;
        end
        slot0_value_reg     <= slot0_value_next;
        slot0_row_end_reg   <= slot0_row_end_next;
        slot0_frame_end_reg <= slot0_frame_end_next;
        slot1_value_reg     <= slot1_value_next;
    end

    assign m_tvalid = (out_cnt_reg != OUT_EMPTY);
    assign m_tdata  = slot0_value_reg;
    assign m_tlast  = slot0_row_end_reg;
    assign m_tuser  = slot0_frame_end_reg;

endmodule

FILE: rtl/wm3s_checker.sv
// Port-level checks of the weighted 3x3 mean smoother, bound to the top level.
// Depends on wm3s_pkg and weighted_mean_3x3_smoother_defines.svh.
`include "weighted_mean_3x3_smoother_defines.svh"

module wm3s_checker import wm3s_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_tready,
    input logic               m_tvalid,
    input logic               m_tready,
    input logic [PIXEL_W-1:0] m_tdata,
    input logic               m_tlast,
    input logic               m_tuser
);

    // Row-end mark of the last result item taken
    logic prev_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_last_reg <= 1'b0;
        end else if (m_tvalid && m_tready) begin
            prev_last_reg <= m_tlast;
        end
    end

    // Nothing pending right after reset
    `WM3S_ASSERT_RST(a_empty_after_reset, !m_tvalid)

    // A stalled result item holds its payload
    `WM3S_ASSERT_NXT(a_hold_on_stall, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))

    // With the result stage empty the whole pipeline can move
    `WM3S_ASSERT_IMP(a_ready_when_empty, !m_tvalid, s_tready)

    // Frame end only on the last item of a row
    `WM3S_ASSERT_IMP(a_frame_end_is_row_end, m_tvalid && m_tuser, m_tlast)

    // Rows are at least two wide, so row ends never come back to back
    `WM3S_ASSERT_IMP(a_no_double_row_end, m_tvalid && m_tready && m_tlast, !prev_last_reg)

endmodule

bind weighted_mean_3x3_smoother wm3s_checker u_wm3s_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);
